@@ rtl/framed_packet_receiver_fletcher8_top_assert.svh @@
// Assertion macros for the framed packet receiver.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FRAMED_PACKET_RECEIVER_FLETCHER8_TOP_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_FLETCHER8_TOP_ASSERT_SVH

// same-cycle implication
`define FPRF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fprf assertion failed");

// next-cycle implication
`define FPRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fprf assertion failed");

`endif

@@ rtl/fprf_pkg.sv @@
// Package for the framed packet receiver: constants, microcode types and
// the control store. No dependencies.
package fprf_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 24;

  localparam logic [7:0] HDR_FIRST  = 8'h41;
  localparam logic [7:0] HDR_SECOND = 8'h43;

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_HUNT1     = 4'd0;
  localparam upc_t UA_HUNT2     = 4'd1;
  localparam upc_t UA_TYPE      = 4'd2;
  localparam upc_t UA_LEN       = 4'd3;
  localparam upc_t UA_LEN0      = 4'd4;
  localparam upc_t UA_DATA      = 4'd5;
  localparam upc_t UA_SUM1      = 4'd6;
  localparam upc_t UA_SUM2      = 4'd7;
  localparam upc_t UA_CHKW      = 4'd8;
  localparam upc_t UA_READ      = 4'd9;
  localparam upc_t UA_SHIFT     = 4'd10;
  localparam upc_t UA_EMIT      = 4'd11;
  localparam upc_t UA_DONE      = 4'd12;
  localparam upc_t UA_EMIT_SHRT = 4'd13;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLR_SUMS,
    ACT_TYPE,
    ACT_LEN,
    ACT_DATA,
    ACT_CLR_CNT,
    ACT_READ,
    ACT_SHIFT,
    ACT_EMIT,
    ACT_EMIT_SHORT
  } act_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NE_A,
    COND_NE_C,
    COND_LEN_BAD,
    COND_LEN_ZERO,
    COND_CNT_LT_LEN,
    COND_NE_SUMA,
    COND_NE_SUMB,
    COND_SHORT,
    COND_PART_WORD,
    COND_MORE
  } cond_t;

  // take: step consumes one input byte; emit: step loads the output register
  typedef struct packed {
    logic  take;
    logic  emit;
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      UA_HUNT1:     w = '{1'b1, 1'b0, ACT_NONE,       COND_NE_A,       UA_HUNT1};
      UA_HUNT2:     w = '{1'b1, 1'b0, ACT_CLR_SUMS,   COND_NE_C,       UA_HUNT1};
      UA_TYPE:      w = '{1'b1, 1'b0, ACT_TYPE,       COND_NEVER,      UA_HUNT1};
      UA_LEN:       w = '{1'b1, 1'b0, ACT_LEN,        COND_LEN_BAD,    UA_HUNT1};
      UA_LEN0:      w = '{1'b0, 1'b0, ACT_NONE,       COND_LEN_ZERO,   UA_SUM1};
      UA_DATA:      w = '{1'b1, 1'b0, ACT_DATA,       COND_CNT_LT_LEN, UA_DATA};
      UA_SUM1:      w = '{1'b1, 1'b0, ACT_NONE,       COND_NE_SUMA,    UA_HUNT1};
      UA_SUM2:      w = '{1'b1, 1'b0, ACT_CLR_CNT,    COND_NE_SUMB,    UA_HUNT1};
      UA_CHKW:      w = '{1'b0, 1'b0, ACT_NONE,       COND_SHORT,      UA_EMIT_SHRT};
      UA_READ:      w = '{1'b0, 1'b0, ACT_READ,       COND_NEVER,      UA_HUNT1};
      UA_SHIFT:     w = '{1'b0, 1'b0, ACT_SHIFT,      COND_PART_WORD,  UA_READ};
      UA_EMIT:      w = '{1'b0, 1'b1, ACT_EMIT,       COND_MORE,       UA_READ};
      UA_DONE:      w = '{1'b0, 1'b0, ACT_NONE,       COND_ALWAYS,     UA_HUNT1};
      UA_EMIT_SHRT: w = '{1'b0, 1'b1, ACT_EMIT_SHORT, COND_ALWAYS,     UA_HUNT1};
      default:      w = '{1'b0, 1'b0, ACT_NONE,       COND_ALWAYS,     UA_HUNT1};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/framed_packet_receiver_fletcher8_top.sv @@
// Framed packet receiver with 8-bit Fletcher checksum, microcoded control.
// Depends on fprf_pkg and framed_packet_receiver_fletcher8_top_assert.svh.
//
// Takes one serial byte per transaction, hunts for the 'A','C' header, then
// reads type, length (0..MAX_PAYLOAD) and payload, and checks the two
// trailing Fletcher sum bytes. A good packet yields one result per full
// little-endian 32-bit payload word (type, word index, word, last), or a
// single result without a word if under four payload bytes came in. Bad
// headers, oversized lengths and checksum mismatches are dropped silently.
// Rate: a sequencer of one control word per cycle steps through the frame
// while no word waits for an input byte or for the output register. Each
// header, type, payload and checksum byte is taken by its own word, and a
// further word tests the length byte for zero. After the checksums it
// checks the length, then per word does four reads of the single-port
// payload store, each followed by a shift into the word, and loads the
// output register, then returns to the hunt; a short packet only loads
// its result. No input is taken during that time. The output register lets
// the reads and shifts go on while a result waits; a load waits until the
// previous result has been taken.
module framed_packet_receiver_fletcher8_top #(
  parameter int unsigned MAX_PAYLOAD = fprf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pkt_type,
  output logic [2:0]  out_word_index,
  output logic [31:0] out_param_word,
  output logic        out_has_param,
  output logic        out_last
);

  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

  fprf_pkg::upc_t   upc_r, upc_nxt;
  fprf_pkg::uword_t uw;

  logic          step_go;
  logic          cond_hit;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    sum_a_r, sum_a_nxt;
  logic [7:0]    sum_b_r, sum_b_nxt;
  logic [7:0]    acc_a, acc_b;
  logic [31:0]   word_r, word_nxt;
  logic [2:0]    widx_r, widx_nxt;
  logic [7:0]    rd_data_r;
  logic          mem_we, mem_re;
  logic          more_words;

  logic [7:0]    mem [MAX_PAYLOAD];

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_type_r, out_type_nxt;
  logic [2:0]    out_widx_r, out_widx_nxt;
  logic [31:0]   out_word_r, out_word_nxt;
  logic          out_has_r, out_has_nxt;
  logic          out_last_r, out_last_nxt;

  assign uw       = fprf_pkg::ucode(upc_r);
  assign in_stall = !uw.take;
  assign step_go  = uw.take ? in_valid : (uw.emit ? (!out_valid_r || !out_stall) : 1'b1);

  assign acc_a = sum_a_r + in_rx_byte;
  assign acc_b = sum_b_r + acc_a;

  assign more_words = (({2'b00, cnt_r} + (LW + 2)'(4)) <= {2'b00, len_r});

  always_comb begin
    case (uw.cond)
      fprf_pkg::COND_NEVER:      cond_hit = 1'b0;
      fprf_pkg::COND_ALWAYS:     cond_hit = 1'b1;
      fprf_pkg::COND_NE_A:       cond_hit = (in_rx_byte != fprf_pkg::HDR_FIRST);
      fprf_pkg::COND_NE_C:       cond_hit = (in_rx_byte != fprf_pkg::HDR_SECOND);
      fprf_pkg::COND_LEN_BAD:    cond_hit = (in_rx_byte > MAX_B);
      fprf_pkg::COND_LEN_ZERO:   cond_hit = (len_r == '0);
      fprf_pkg::COND_CNT_LT_LEN: cond_hit = (({1'b0, cnt_r} + 1'b1) < {1'b0, len_r});
      fprf_pkg::COND_NE_SUMA:    cond_hit = (in_rx_byte != sum_a_r);
      fprf_pkg::COND_NE_SUMB:    cond_hit = (in_rx_byte != sum_b_r);
      fprf_pkg::COND_SHORT:      cond_hit = (len_r < LW'(4));
      fprf_pkg::COND_PART_WORD:  cond_hit = (cnt_r[1:0] != 2'b00);
      fprf_pkg::COND_MORE:       cond_hit = more_words;
      default:                   cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt = upc_r;
    if (step_go) begin
      upc_nxt = cond_hit ? uw.target : fprf_pkg::upc_t'(upc_r + 1'b1);
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    word_nxt      = word_r;
    widx_nxt      = widx_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_type_nxt  = out_type_r;
    out_widx_nxt  = out_widx_r;
    out_word_nxt  = out_word_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    if (step_go) begin
      case (uw.act)
        fprf_pkg::ACT_NONE: begin
        end
        fprf_pkg::ACT_CLR_SUMS: begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end
        fprf_pkg::ACT_TYPE: begin
          type_nxt  = in_rx_byte;
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
        end
        fprf_pkg::ACT_LEN: begin
          len_nxt   = in_rx_byte[LW-1:0];
          cnt_nxt   = '0;
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
        end
        fprf_pkg::ACT_DATA: begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
        end
        fprf_pkg::ACT_CLR_CNT: begin
          cnt_nxt  = '0;
          widx_nxt = '0;
        end
        fprf_pkg::ACT_READ: begin
          mem_re  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        fprf_pkg::ACT_SHIFT: begin
          word_nxt = {rd_data_r, word_r[31:8]};
        end
        fprf_pkg::ACT_EMIT: begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = type_r;
          out_widx_nxt  = widx_r;
          out_word_nxt  = word_r;
          out_has_nxt   = 1'b1;
          out_last_nxt  = !more_words;
          widx_nxt      = widx_r + 1'b1;
        end
        fprf_pkg::ACT_EMIT_SHORT: begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = type_r;
          out_widx_nxt  = '0;
          out_word_nxt  = '0;
          out_has_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= fprf_pkg::UA_HUNT1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      widx_r      <= '0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      widx_r      <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    type_r     <= type_nxt;
    sum_a_r    <= sum_a_nxt;
    sum_b_r    <= sum_b_nxt;
    word_r     <= word_nxt;
    out_type_r <= out_type_nxt;
    out_widx_r <= out_widx_nxt;
    out_word_r <= out_word_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
  end

  // payload store, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[cnt_r[AW-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pkt_type   = out_type_r;
  assign out_word_index = out_widx_r;
  assign out_param_word = out_word_r;
  assign out_has_param  = out_has_r;
  assign out_last       = out_last_r;

`include "framed_packet_receiver_fletcher8_top_assert.svh"

  `FPRF_ASSERT_IMPL(a_data_in_range, upc_r == fprf_pkg::UA_DATA, cnt_r < len_r)
  `FPRF_ASSERT_IMPL(a_emit_word_aligned, upc_r == fprf_pkg::UA_EMIT, cnt_r[1:0] == 2'b00)
  `FPRF_ASSERT_IMPL(a_short_is_last, out_valid_r && !out_has_r, out_last_r)
  `FPRF_ASSERT_NEXT(a_emit_loads_out, step_go && uw.emit, out_valid_r)

endmodule

@@ tb/framed_packet_receiver_fletcher8_top_test.sv @@
// Testbench for framed_packet_receiver_fletcher8_top: streams directed and random
// frames in, predicts every decoded result and checks it field by field.
// Depends on fprf_pkg and the receiver RTL.
module framed_packet_receiver_fletcher8_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYNC_MARK = -1;
  localparam int RANDOM_FILL = -1;
  localparam int TAIL_CYCLES = 120;

  typedef enum logic [2:0] {PH_HUNT, PH_TYPE, PH_LEN, PH_DATA, PH_SUM} rx_phase_e;
  typedef enum logic [1:0] {FR_GOOD, FR_BAD_A, FR_BAD_B} frame_kind_e;

  typedef struct {
    logic [7:0]  pkt_type;
    logic [2:0]  word_index;
    logic [31:0] param_word;
    logic        has_param;
    logic        last;
  } pkt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pkt_type;
  logic [2:0]  out_word_index;
  logic [31:0] out_param_word;
  logic        out_has_param;
  logic        out_last;

  int          stim_q[$];
  pkt_result_t pending_results[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          tx_gap = 0;
  bit          tx_calm = 1'b0;
  int          rx_stall_left = 0;
  int          rx_hold_left = 0;
  bit          rx_calm = 1'b0;

  // predictor state
  rx_phase_e   rx_phase = PH_HUNT;
  logic [4:0]  rx_cnt = '0;
  logic [7:0]  type_q = '0;
  logic [4:0]  len_q = '0;
  logic [7:0]  run_a = '0;
  logic [7:0]  run_b = '0;
  logic [7:0]  frame_bytes [fprf_pkg::MAX_PAYLOAD_DEF];

  framed_packet_receiver_fletcher8_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pkt_type   (out_pkt_type),
    .out_word_index (out_word_index),
    .out_param_word (out_param_word),
    .out_has_param  (out_has_param),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void fold_sums(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int          n_words;
    pkt_result_t r;
    case (rx_phase)
      PH_HUNT: begin
        if (rx_cnt == 0) begin
          if (b == fprf_pkg::HDR_FIRST) rx_cnt = 5'd1;
        end else if (b == fprf_pkg::HDR_SECOND) begin
          rx_phase = PH_TYPE;
          rx_cnt = '0;
          run_a = '0;
          run_b = '0;
        end else begin
          rx_cnt = '0;
        end
      end
      PH_TYPE: begin
        type_q = b;
        fold_sums(b);
        rx_phase = PH_LEN;
        rx_cnt = '0;
      end
      PH_LEN: begin
        if (b > fprf_pkg::MAX_PAYLOAD_DEF) begin
          rx_phase = PH_HUNT;
          rx_cnt = '0;
        end else begin
          len_q = b[4:0];
          fold_sums(b);
          rx_phase = (b == 0) ? PH_SUM : PH_DATA;
          rx_cnt = '0;
        end
      end
      PH_DATA: begin
        frame_bytes[rx_cnt] = b;
        fold_sums(b);
        rx_cnt = rx_cnt + 5'd1;
        if (rx_cnt >= len_q) begin
          rx_phase = PH_SUM;
          rx_cnt = '0;
        end
      end
      PH_SUM: begin
        if (rx_cnt == 0) begin
          if (b != run_a) begin
            rx_phase = PH_HUNT;
            rx_cnt = '0;
          end else begin
            rx_cnt = 5'd1;
          end
        end else begin
          if (b == run_b) begin
            n_words = len_q / 4;
            if (n_words == 0) begin
              r = '{type_q, 3'd0, 32'd0, 1'b0, 1'b1};
              pending_results.push_back(r);
            end
            for (int k = 0; k < n_words; k++) begin
              r.pkt_type = type_q;
              r.word_index = k[2:0];
              r.param_word = {frame_bytes[4*k+3], frame_bytes[4*k+2],
                              frame_bytes[4*k+1], frame_bytes[4*k]};
              r.has_param = 1'b1;
              r.last = (k == n_words - 1);
              pending_results.push_back(r);
            end
          end
          rx_phase = PH_HUNT;
          rx_cnt = '0;
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        rx_cnt = '0;
      end
    endcase
  endtask

  task automatic push_frame(input logic [7:0] ftype, input int flen, input int fill,
                            input frame_kind_e kind);
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] d;
    sa = '0;
    sb = '0;
    stim_q.push_back(int'(fprf_pkg::HDR_FIRST));
    stim_q.push_back(int'(fprf_pkg::HDR_SECOND));
    stim_q.push_back(int'(ftype));
    sa = sa + ftype;
    sb = sb + sa;
    stim_q.push_back(flen);
    sa = sa + flen[7:0];
    sb = sb + sa;
    for (int i = 0; i < flen; i++) begin
      d = (fill == RANDOM_FILL) ? 8'($urandom_range(0, 255)) : fill[7:0];
      stim_q.push_back(int'(d));
      sa = sa + d;
      sb = sb + sa;
    end
    if (kind == FR_BAD_A) sa = sa ^ (8'd1 << $urandom_range(0, 7));
    if (kind == FR_BAD_B) sb = sb ^ (8'd1 << $urandom_range(0, 7));
    stim_q.push_back(int'(sa));
    stim_q.push_back(int'(sb));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 3);
    if (r < 80) return $urandom_range(0, fprf_pkg::MAX_PAYLOAD_DEF);
    return fprf_pkg::MAX_PAYLOAD_DEF;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0 && stim_q[0] == SYNC_MARK) begin
          in_valid <= 1'b0;
          if (pending_results.size() == 0) void'(stim_q.pop_front());
        end else if (stim_q.size() > 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= 8'(stim_q.pop_front());
          tx_gap = tx_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pkt_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_seen == 12 || results_seen == 180) rx_hold_left = 250;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction, type %h word %h", $realtime,
                   out_pkt_type, out_param_word);
        end else begin
          e = pending_results.pop_front();
          if (out_pkt_type !== e.pkt_type) begin
            mismatch_count++;
            $display("%0t: pkt_type expected %h actual %h", $realtime,
                     e.pkt_type, out_pkt_type);
          end
          if (out_word_index !== e.word_index) begin
            mismatch_count++;
            $display("%0t: word_index expected %0d actual %0d", $realtime,
                     e.word_index, out_word_index);
          end
          if (out_param_word !== e.param_word) begin
            mismatch_count++;
            $display("%0t: param_word expected %h actual %h", $realtime,
                     e.param_word, out_param_word);
          end
          if (out_has_param !== e.has_param) begin
            mismatch_count++;
            $display("%0t: has_param expected %b actual %b", $realtime,
                     e.has_param, out_has_param);
          end
          if (out_last !== e.last) begin
            mismatch_count++;
            $display("%0t: last expected %b actual %b", $realtime, e.last, out_last);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (rx_stall_left == 0 && !rx_calm && $urandom_range(0, 3) == 0)
          rx_stall_left = pick_gap();
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int  pick;
    bit  mid_sync;
    logic [7:0] junk;
    mid_sync = 1'b0;

    // directed: zero length, broken header, all-ones word, oversized, bad sum
    push_frame(8'h00, 0, 0, FR_GOOD);
    stim_q.push_back(int'(fprf_pkg::HDR_FIRST));
    stim_q.push_back(int'(fprf_pkg::HDR_FIRST));
    stim_q.push_back(int'(fprf_pkg::HDR_SECOND));
    push_frame(8'hFF, 4, 8'hFF, FR_GOOD);
    stim_q.push_back(int'(fprf_pkg::HDR_FIRST));
    stim_q.push_back(int'(fprf_pkg::HDR_SECOND));
    stim_q.push_back(int'(8'h80));
    stim_q.push_back(int'(fprf_pkg::MAX_PAYLOAD_DEF + 1));
    push_frame(8'h5A, 0, 0, FR_BAD_A);
    stim_q.push_back(SYNC_MARK);

    while (stim_q.size() < 468) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        push_frame(8'($urandom_range(0, 255)), pick_len(), RANDOM_FILL, FR_GOOD);
      end else if (pick < 72) begin
        push_frame(8'($urandom_range(0, 255)), pick_len(), RANDOM_FILL, FR_BAD_A);
      end else if (pick < 79) begin
        push_frame(8'($urandom_range(0, 255)), pick_len(), RANDOM_FILL, FR_BAD_B);
      end else if (pick < 85) begin
        stim_q.push_back(int'(fprf_pkg::HDR_FIRST));
        stim_q.push_back(int'(fprf_pkg::HDR_SECOND));
        stim_q.push_back($urandom_range(0, 255));
        stim_q.push_back($urandom_range(fprf_pkg::MAX_PAYLOAD_DEF + 1, 255));
        repeat ($urandom_range(0, 4)) stim_q.push_back($urandom_range(0, 255));
      end else if (pick < 92) begin
        junk = 8'($urandom_range(0, 255));
        stim_q.push_back(int'(fprf_pkg::HDR_FIRST));
        stim_q.push_back(int'(junk));
      end else begin
        repeat ($urandom_range(1, 6)) stim_q.push_back($urandom_range(0, 255));
      end
      if (!mid_sync && stim_q.size() > 280) begin
        stim_q.push_back(SYNC_MARK);
        mid_sync = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (stim_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fprf_pkg.sv
rtl/framed_packet_receiver_fletcher8_top.sv
tb/framed_packet_receiver_fletcher8_top_test.sv
